### rtl/assert_macros.svh
// Assertion macros for RTL files that check themselves; neighbor_alias_table includes them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AST_IMPLY(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Condition that must hold on every rising clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

### rtl/nat_pkg.sv
// Shared types and constants of the neighbor alias table.
// No dependencies; used by nat_ctrl, nat_dp and neighbor_alias_table.
`default_nettype none
package nat_pkg;
   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = 6;
   localparam int ALIAS_SPAN  = 254;

   typedef logic [2:0] mode_type;
   localparam mode_type MODE_HEARD   = 3'd0;
   localparam mode_type MODE_PARTNER = 3'd1;
   localparam mode_type MODE_MATCH   = 3'd2;
   localparam mode_type MODE_LOOKUP  = 3'd3;
   localparam mode_type MODE_QUERY   = 3'd4;
   localparam mode_type MODE_PRUNE   = 3'd5;

   typedef logic [1:0] status_type;
   localparam status_type STAT_OK   = 2'd0;
   localparam status_type STAT_FULL = 2'd1;
   localparam status_type STAT_NONE = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_ALIAS_BASE   = 2'd0;
   localparam csr_index_type CSR_IDLE_TIMEOUT = 2'd1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_ALLOC = 6'b000100,
      ST_RESP  = 6'b001000,
      ST_COUNT = 6'b010000,
      ST_PRUNE = 6'b100000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_inc;
      logic       goto_free;
      logic       cand_init;
      logic       cand_step;
      logic       claim;
      logic       touch;
      logic       partner;
      logic       remove;
      logic       rem_inc;
      logic       commit;
      logic       emit;
      logic       emit_use;
      logic       emit_last;
      status_type emit_status;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     idx_last;
      logic     match;
      logic     free_any;
      logic     expired;
      logic     cand_free;
      logic     cand_last;
      logic     rem_zero;
      logic     prune_last;
   } stat_type;
endpackage
`default_nettype wire

### rtl/neighbor_alias_table.sv
// Top level of the neighbor alias table: controller plus datapath.
// Depends on nat_pkg, nat_ctrl, nat_dp and assert_macros.svh.
//
//   channel | ports                        | handshake
//   request | start, busy, req_*           | taken when start && !busy
//   result  | rsp_valid, rsp_*             | one-cycle strobe, no backpressure
//   config  | csr_valid, csr_ready, csr_*  | valid && ready, ready always high
//
// Heard, set-partner, match, lookup and query walk the slots one per cycle. Claiming a
// slot adds a search for a free alias: at most 31 aliases are taken, so the search ends
// within 32 candidates, followed by a response state. Prune makes two walks (count,
// then remove) and emits one beat per removed entry. Unused modes answer from idle.
// Synchronous reset clears the table at once; no clearing pass; the receiver cannot stall.
`default_nettype none
module neighbor_alias_table (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire nat_pkg::mode_type      req_mode,
   input  wire logic [31:0]            req_node_id,
   input  wire logic [31:0]            req_now_time,
   input  wire logic [7:0]             req_alias_a,
   input  wire logic [7:0]             req_alias_b,
   output logic                        rsp_valid,
   output nat_pkg::status_type         rsp_status,
   output logic [31:0]                 rsp_node_out,
   output logic [7:0]                  rsp_my_alias_out,
   output logic [7:0]                  rsp_their_alias_out,
   output logic [nat_pkg::CNT_W-1:0]   rsp_neighbor_count,
   output logic                        rsp_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire nat_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data
);
   import nat_pkg::*;
   `include "assert_macros.svh"

   cmd_type    cmd;
   stat_type   stat;
   logic       fail_beat, fail_clear;
   logic [3:0] slot_writes;

   assign csr_ready = 1'b1;

   nat_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   nat_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_node_id         (req_node_id),
      .req_now_time        (req_now_time),
      .req_alias_a         (req_alias_a),
      .req_alias_b         (req_alias_b),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_node_out        (rsp_node_out),
      .rsp_my_alias_out    (rsp_my_alias_out),
      .rsp_their_alias_out (rsp_their_alias_out),
      .rsp_neighbor_count  (rsp_neighbor_count),
      .rsp_last            (rsp_last)
   );

   assign fail_beat   = rsp_valid && (rsp_status != STAT_OK);
   assign fail_clear  = (rsp_node_out == 32'd0) && (rsp_my_alias_out == 8'd0);
   assign slot_writes = {cmd.claim, cmd.touch, cmd.partner, cmd.remove};

   `AST_IMPLY(a_fail_zero, clock, reset, fail_beat, fail_clear)
   `AST_IMPLY(a_count_max, clock, reset, rsp_valid, rsp_neighbor_count <= CNT_W'(TABLE_SLOTS))
   `AST_IMPLY(a_remove_emits, clock, reset, cmd.remove, cmd.emit && cmd.emit_use)
   `AST_ALWAYS(a_single_write, clock, reset, $onehot0(slot_writes))
endmodule
`default_nettype wire

### rtl/nat_ctrl.sv
// Controller state machine of the neighbor alias table.
// Depends on nat_pkg; drives nat_dp through cmd_type, reads stat_type.
`default_nettype none
module nat_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire nat_pkg::mode_type req_mode,
   input  wire nat_pkg::stat_type stat,
   output nat_pkg::cmd_type       cmd,
   output logic                   busy
);
   import nat_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_mode)
                  MODE_PRUNE: state_in = ST_COUNT;
                  MODE_HEARD, MODE_PARTNER, MODE_MATCH, MODE_LOOKUP, MODE_QUERY:
                     state_in = ST_SCAN;
                  default: begin
                     cmd.emit        = 1'b1;
                     cmd.emit_last   = 1'b1;
                     cmd.emit_status = STAT_NONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.match) begin
               cmd.emit        = 1'b1;
               cmd.emit_use    = 1'b1;
               cmd.emit_last   = 1'b1;
               cmd.emit_status = STAT_OK;
               cmd.touch       = (stat.mode == MODE_HEARD);
               cmd.partner     = (stat.mode == MODE_PARTNER);
               state_in        = ST_IDLE;
            end else if (stat.idx_last) begin
               if (stat.mode == MODE_HEARD && stat.free_any) begin
                  cmd.goto_free = 1'b1;
                  cmd.cand_init = 1'b1;
                  state_in      = ST_ALLOC;
               end else begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = (stat.mode == MODE_HEARD) ? STAT_FULL : STAT_NONE;
                  state_in        = ST_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_ALLOC: begin
            if (stat.cand_free || stat.cand_last) begin
               cmd.claim = 1'b1;
               state_in  = ST_RESP;
            end else begin
               cmd.cand_step = 1'b1;
            end
         end
         ST_RESP: begin
            cmd.emit        = 1'b1;
            cmd.emit_use    = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = STAT_OK;
            state_in        = ST_IDLE;
         end
         ST_COUNT: begin
            cmd.rem_inc = stat.expired;
            if (stat.idx_last) begin
               cmd.commit = 1'b1;
               if (stat.rem_zero) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_last   = 1'b1;
                  cmd.emit_status = STAT_NONE;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_PRUNE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_PRUNE: begin
            if (stat.expired) begin
               cmd.remove      = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_use    = 1'b1;
               cmd.emit_last   = stat.prune_last;
               cmd.emit_status = STAT_OK;
            end
            if ((stat.expired && stat.prune_last) || stat.idx_last) begin
               state_in = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### rtl/nat_dp.sv
// Datapath of the neighbor alias table: slot store, alias map, walk counters,
// configuration registers and the result register. Depends on nat_pkg.
`default_nettype none
module nat_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nat_pkg::cmd_type       cmd,
   output nat_pkg::stat_type           stat,
   input  wire nat_pkg::mode_type      req_mode,
   input  wire logic [31:0]            req_node_id,
   input  wire logic [31:0]            req_now_time,
   input  wire logic [7:0]             req_alias_a,
   input  wire logic [7:0]             req_alias_b,
   input  wire logic                   csr_valid,
   input  wire nat_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data,
   output logic                        rsp_valid,
   output nat_pkg::status_type         rsp_status,
   output logic [31:0]                 rsp_node_out,
   output logic [7:0]                  rsp_my_alias_out,
   output logic [7:0]                  rsp_their_alias_out,
   output logic [nat_pkg::CNT_W-1:0]   rsp_neighbor_count,
   output logic                        rsp_last
);
   import nat_pkg::*;

   logic [7:0]  alias_base_ff;
   logic [31:0] idle_timeout_ff;

   mode_type    mode_ff;
   logic [31:0] id_ff, now_ff;
   logic [7:0]  a_ff, b_ff;

   logic [TABLE_SLOTS-1:0] valid_ff;
   logic [31:0] node_ff  [TABLE_SLOTS];
   logic [7:0]  my_ff    [TABLE_SLOTS];
   logic [7:0]  their_ff [TABLE_SLOTS];
   logic [31:0] heard_ff [TABLE_SLOTS];
   logic [255:0] used_ff;

   logic [SLOT_W-1:0] idx_ff, free_idx_ff;
   logic              free_found_ff;
   logic [7:0]        cand_ff, k_ff;
   logic [CNT_W-1:0]  count_ff, rem_ff, emitted_ff;

   logic [31:0] age;
   logic        node_hit, alias_hit, cur_free;
   logic [7:0]  base_mod, new_alias;
   logic [CNT_W-1:0] rem_total;

   assign cur_free  = !valid_ff[idx_ff];
   assign node_hit  = valid_ff[idx_ff] && (node_ff[idx_ff] == id_ff);
   assign alias_hit = (a_ff != 8'd0) && valid_ff[idx_ff] && (my_ff[idx_ff] == a_ff)
                      && (mode_ff == MODE_LOOKUP || their_ff[idx_ff] == b_ff);
   assign age       = now_ff - heard_ff[idx_ff];
   assign rem_total = rem_ff + CNT_W'(stat.expired);
   assign base_mod  = (alias_base_ff >= 8'(ALIAS_SPAN)) ? alias_base_ff - 8'(ALIAS_SPAN)
                                                        : alias_base_ff;
   assign new_alias = used_ff[cand_ff] ? 8'd0 : cand_ff;

   always_comb begin
      stat            = '0;
      stat.mode       = mode_ff;
      stat.idx_last   = (idx_ff == SLOT_W'(TABLE_SLOTS - 1));
      stat.match      = (mode_ff == MODE_MATCH || mode_ff == MODE_LOOKUP) ? alias_hit : node_hit;
      stat.free_any   = free_found_ff || cur_free;
      stat.expired    = valid_ff[idx_ff] && (age > idle_timeout_ff);
      stat.cand_free  = !used_ff[cand_ff];
      stat.cand_last  = (k_ff == 8'(ALIAS_SPAN - 1));
      stat.rem_zero   = (rem_total == '0);
      stat.prune_last = ((emitted_ff + CNT_W'(1)) == rem_ff);
   end

   // configuration, control counters and maps
   always_ff @(posedge clock) begin
      if (reset) begin
         alias_base_ff   <= 8'd0;
         idle_timeout_ff <= 32'd60000;
         valid_ff        <= '0;
         used_ff         <= '0;
         count_ff        <= '0;
         rsp_valid       <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_ALIAS_BASE:   alias_base_ff   <= csr_data[7:0];
               CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.claim) begin
            valid_ff[idx_ff] <= 1'b1;
            if (new_alias != 8'd0) used_ff[new_alias] <= 1'b1;
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.remove) begin
            valid_ff[idx_ff]      <= 1'b0;
            used_ff[my_ff[idx_ff]] <= 1'b0;
         end
         if (cmd.commit) count_ff <= count_ff - rem_total;
         rsp_valid <= cmd.emit;
      end
   end

   // walk state and latched request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff       <= req_mode;
         id_ff         <= req_node_id;
         now_ff        <= req_now_time;
         a_ff          <= req_alias_a;
         b_ff          <= req_alias_b;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         free_idx_ff   <= '0;
         rem_ff        <= '0;
         emitted_ff    <= '0;
      end else begin
         if (cmd.idx_clr) idx_ff <= '0;
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + SLOT_W'(1);
            if (cur_free && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= idx_ff;
            end
         end
         if (cmd.goto_free && free_found_ff) idx_ff <= free_idx_ff;
         if (cmd.rem_inc) rem_ff <= rem_ff + CNT_W'(1);
         if (cmd.remove)  emitted_ff <= emitted_ff + CNT_W'(1);
      end
      if (cmd.cand_init) begin
         cand_ff <= base_mod + 8'd1;
         k_ff    <= 8'd0;
      end else if (cmd.cand_step) begin
         cand_ff <= (cand_ff == 8'(ALIAS_SPAN)) ? 8'd1 : cand_ff + 8'd1;
         k_ff    <= k_ff + 8'd1;
      end
   end

   // slot payload store
   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         node_ff[idx_ff]  <= id_ff;
         my_ff[idx_ff]    <= new_alias;
         their_ff[idx_ff] <= 8'd0;
         heard_ff[idx_ff] <= now_ff;
      end
      if (cmd.touch)   heard_ff[idx_ff] <= now_ff;
      if (cmd.partner) their_ff[idx_ff] <= a_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status          <= cmd.emit_status;
         rsp_node_out        <= cmd.emit_use ? node_ff[idx_ff] : 32'd0;
         rsp_my_alias_out    <= cmd.emit_use ? my_ff[idx_ff] : 8'd0;
         rsp_their_alias_out <= !cmd.emit_use ? 8'd0 : (cmd.partner ? a_ff : their_ff[idx_ff]);
         rsp_neighbor_count  <= cmd.commit ? count_ff - rem_total : count_ff;
         rsp_last            <= cmd.emit_last;
      end
   end
endmodule
`default_nettype wire

### tb/sv/neighbor_alias_table_checker.sv
// Checker for the neighbor alias table: watches request, result and register beats,
// keeps its own copy of the table and compares every result beat. Depends on nat_pkg.
`default_nettype none
module neighbor_alias_table_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   busy,
   input  wire nat_pkg::mode_type      req_mode,
   input  wire logic [31:0]            req_node_id,
   input  wire logic [31:0]            req_now_time,
   input  wire logic [7:0]             req_alias_a,
   input  wire logic [7:0]             req_alias_b,
   input  wire logic                   rsp_valid,
   input  wire nat_pkg::status_type    rsp_status,
   input  wire logic [31:0]            rsp_node_out,
   input  wire logic [7:0]             rsp_my_alias_out,
   input  wire logic [7:0]             rsp_their_alias_out,
   input  wire logic [5:0]             rsp_neighbor_count,
   input  wire logic                   rsp_last,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire nat_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_data,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import nat_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] node;
      logic [7:0]  mine;
      logic [7:0]  theirs;
      logic [5:0]  count;
      logic        last;
   } beat_type;

   beat_type    beat_q[$];
   logic [7:0]  base_r;
   logic [31:0] timeout_r;
   logic        used[TABLE_SLOTS];
   logic [31:0] node_r[TABLE_SLOTS];
   logic [7:0]  mine_r[TABLE_SLOTS];
   logic [7:0]  theirs_r[TABLE_SLOTS];
   logic [31:0] heard_r[TABLE_SLOTS];

   assign pending = beat_q.size();

   function automatic int find_id(logic [31:0] id);
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (used[i] && node_r[i] == id) return i;
      return -1;
   endfunction

   function automatic logic [7:0] free_alias();
      int   cand;
      logic taken;
      for (int k = 0; k < ALIAS_SPAN; k++) begin
         cand = 1 + (int'(base_r) + k) % ALIAS_SPAN;
         taken = 0;
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (used[i] && mine_r[i] == cand) taken = 1;
         if (!taken) return cand[7:0];
      end
      return 8'd0;
   endfunction

   function automatic beat_type slot_beat(status_type st, int s);
      beat_type b;
      b = '0;
      b.status = st;
      if (s >= 0) begin
         b.node = node_r[s];
         b.mine = mine_r[s];
         b.theirs = theirs_r[s];
      end
      return b;
   endfunction

   task automatic predict_table_step(mode_type m, logic [31:0] id, logic [31:0] now,
                                     logic [7:0] a, logic [7:0] b);
      beat_type out[$];
      int       s;
      int       cnt;
      s = -1;
      case (m)
         MODE_HEARD: begin
            s = find_id(id);
            if (s < 0) begin
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (!used[i] && s < 0) s = i;
               if (s >= 0) begin
                  mine_r[s] = free_alias();
                  used[s] = 1;
                  node_r[s] = id;
                  theirs_r[s] = 0;
               end
            end
            if (s < 0) out.push_back(slot_beat(STAT_FULL, -1));
            else begin
               heard_r[s] = now;
               out.push_back(slot_beat(STAT_OK, s));
            end
         end
         MODE_PARTNER: begin
            s = find_id(id);
            if (s >= 0) theirs_r[s] = a;
            out.push_back(slot_beat(s >= 0 ? STAT_OK : STAT_NONE, s));
         end
         MODE_MATCH, MODE_LOOKUP: begin
            if (a != 0)
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (s < 0 && used[i] && mine_r[i] == a &&
                      (m == MODE_LOOKUP || theirs_r[i] == b)) s = i;
            out.push_back(slot_beat(s >= 0 ? STAT_OK : STAT_NONE, s));
         end
         MODE_QUERY: begin
            s = find_id(id);
            out.push_back(slot_beat(s >= 0 ? STAT_OK : STAT_NONE, s));
         end
         MODE_PRUNE: begin
            for (int i = 0; i < TABLE_SLOTS; i++)
               if (used[i] && (now - heard_r[i]) > timeout_r) begin
                  if (out.size() < 32) out.push_back(slot_beat(STAT_OK, i));
                  used[i] = 0;
               end
            if (out.size() == 0) out.push_back(slot_beat(STAT_NONE, -1));
         end
         default: out.push_back(slot_beat(STAT_NONE, -1));
      endcase
      cnt = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) cnt += used[i];
      foreach (out[k]) begin
         out[k].count = cnt[5:0];
         out[k].last = (k == out.size() - 1);
         beat_q.push_back(out[k]);
      end
   endtask

   always @(posedge clock) begin
      beat_type want, got;
      if (reset) begin
         base_r = 0;
         timeout_r = 60000;
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            used[i] = 0;
            node_r[i] = 0;
            mine_r[i] = 0;
            theirs_r[i] = 0;
            heard_r[i] = 0;
         end
         beat_q.delete();
         fail_count = 0;
      end else begin
         // compare before predicting: a result never comes in the cycle of its request
         if (rsp_valid) begin
            got = '{rsp_status, rsp_node_out, rsp_my_alias_out, rsp_their_alias_out,
                    rsp_neighbor_count, rsp_last};
            if (beat_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result beat %h", $time, got);
            end else begin
               want = beat_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: expected st=%0d node=%h my=%0d their=%0d cnt=%0d last=%0d",
                           $time, want.status, want.node, want.mine, want.theirs,
                           want.count, want.last);
                  $display("%0t: actual   st=%0d node=%h my=%0d their=%0d cnt=%0d last=%0d",
                           $time, got.status, got.node, got.mine, got.theirs,
                           got.count, got.last);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ALIAS_BASE) base_r = csr_data[7:0];
            else if (csr_index == CSR_IDLE_TIMEOUT) timeout_r = csr_data;
         end
         if (start && !busy)
            predict_table_step(req_mode, req_node_id, req_now_time, req_alias_a, req_alias_b);
      end
   end
endmodule
`default_nettype wire

### tb/sv/neighbor_alias_table_test.sv
// Top of the neighbor alias table testbench: clock, reset, stimulus and verdict.
// Depends on nat_pkg, neighbor_alias_table and neighbor_alias_table_checker.
`default_nettype none
module neighbor_alias_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import nat_pkg::*;

   logic          clock = 0;
   logic          reset = 1;
   logic          start = 0;
   logic          busy;
   mode_type      req_mode = MODE_HEARD;
   logic [31:0]   req_node_id = 0;
   logic [31:0]   req_now_time = 0;
   logic [7:0]    req_alias_a = 0;
   logic [7:0]    req_alias_b = 0;
   logic          rsp_valid;
   status_type    rsp_status;
   logic [31:0]   rsp_node_out;
   logic [7:0]    rsp_my_alias_out;
   logic [7:0]    rsp_their_alias_out;
   logic [5:0]    rsp_neighbor_count;
   logic          rsp_last;
   logic          csr_valid = 0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_ALIAS_BASE;
   logic [31:0]   csr_data = 0;
   int            fail_count;
   int            pending;
   logic          calm;
   logic [31:0]   clock_ms;
   logic [31:0]   id_pool[8];

   neighbor_alias_table i_dut (.*);
   neighbor_alias_table_checker i_check (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_request(mode_type m, logic [31:0] id, logic [31:0] now,
                               logic [7:0] a, logic [7:0] b);
      while (!calm && $urandom_range(99) < 14) @(posedge clock);
      start <= 1;
      req_mode <= m;
      req_node_id <= id;
      req_now_time <= now;
      req_alias_a <= a;
      req_alias_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 0;
      @(posedge clock);
   endtask

   // drain results, then allow for a trailing walk before touching registers
   task automatic settle();
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic random_phase(int n);
      int          pick, slot;
      logic [31:0] id;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         slot = $urandom_range(7);
         id = ($urandom_range(3) == 0) ? $urandom : id_pool[slot];
         calm = (k >= n / 3 && k < n / 2);
         clock_ms += $urandom_range(20000);
         if (pick < 35)
            send_request(MODE_HEARD, id, clock_ms, $urandom, $urandom);
         else if (pick < 50)
            send_request(MODE_PARTNER, id, $urandom, $urandom_range(1) ? slot + 1 : $urandom,
                         $urandom);
         else if (pick < 62)
            send_request(MODE_MATCH, $urandom, $urandom, $urandom_range(40), $urandom_range(9));
         else if (pick < 74)
            send_request(MODE_LOOKUP, $urandom, $urandom, $urandom_range(40), $urandom);
         else if (pick < 84)
            send_request(MODE_QUERY, id, $urandom, $urandom, $urandom);
         else if (pick < 96)
            send_request(MODE_PRUNE, $urandom, ($urandom_range(9) == 0) ? $urandom : clock_ms,
                         $urandom, $urandom);
         else
            send_request(mode_type'($urandom_range(6, 7)), $urandom, $urandom, $urandom,
                         $urandom);
      end
      calm = 0;
   endtask

   initial begin
      calm = 0;
      clock_ms = 0;
      foreach (id_pool[i]) id_pool[i] = $urandom;
      id_pool[0] = 32'h0;
      id_pool[1] = 32'hFFFF_FFFF;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every operation, full table, mass prune
      send_request(MODE_QUERY, 32'h0, 0, 8'hFF, 8'hFF);
      send_request(MODE_HEARD, 32'h0, 32'hFFFF_FFFF, 0, 0);
      send_request(MODE_HEARD, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(MODE_PARTNER, 32'hFFFF_FFFF, 0, 8'hFF, 0);
      send_request(MODE_PARTNER, 32'h1234_5678, 0, 8'h01, 0);
      send_request(MODE_MATCH, 0, 0, 8'd2, 8'hFF);
      send_request(MODE_MATCH, 0, 0, 8'd0, 8'd0);
      send_request(MODE_LOOKUP, 0, 0, 8'd1, 0);
      send_request(MODE_LOOKUP, 0, 0, 8'd0, 0);
      send_request(MODE_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
      send_request(mode_type'(6), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_request(mode_type'(7), 0, 0, 0, 0);
      for (int i = 0; i < 32; i++) send_request(MODE_HEARD, 32'h100 + i, 1000, 0, 0);
      send_request(MODE_HEARD, 32'hDEAD_BEEF, 1000, 0, 0);
      send_request(MODE_PRUNE, 0, 1000, 0, 0);
      send_request(MODE_PRUNE, 0, 32'hFFFF_FFFF, 0, 0);
      send_request(MODE_HEARD, 32'h55, 0, 0, 0);
      settle();

      write_reg(CSR_ALIAS_BASE, 32'd253);
      write_reg(CSR_IDLE_TIMEOUT, 32'd0);
      write_reg(csr_index_type'(2), 32'hFFFF_FFFF);
      write_reg(csr_index_type'(3), 32'h0);
      clock_ms = 32'hFFFF_0000;
      random_phase(100);
      settle();

      write_reg(CSR_ALIAS_BASE, 32'd0);
      write_reg(CSR_IDLE_TIMEOUT, 32'hFFFF_FFFF);
      random_phase(80);
      settle();

      write_reg(CSR_ALIAS_BASE, 32'hFF);
      write_reg(CSR_IDLE_TIMEOUT, 32'd30000);
      random_phase(100);
      settle();

      write_reg(CSR_ALIAS_BASE, $urandom_range(253));
      write_reg(CSR_IDLE_TIMEOUT, $urandom_range(90000));
      random_phase(100);
      settle();

      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/nat_pkg.sv
rtl/nat_ctrl.sv
rtl/nat_dp.sv
rtl/neighbor_alias_table.sv
tb/sv/neighbor_alias_table_checker.sv
tb/sv/neighbor_alias_table_test.sv
